FILE: rtl/oss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oss_pkg
// Shared constants, codes and types for the order statistic set unit.
// ----------------------------------------------------------------------------
package oss_pkg;

	// Store geometry
	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;

	// Keys are kept with the sign bit flipped so unsigned order is signed order
	localparam logic [KEY_W-1:0] SIGN_FLIP = {1'b1, {(KEY_W-1){1'b0}}};

	// Operation codes
	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_FIND   = 3'd1;
	localparam logic [2:0] OP_REMOVE = 3'd2;
	localparam logic [2:0] OP_SELECT = 3'd3;
	localparam logic [2:0] OP_RANGE  = 3'd4;

	// Status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_BAD_RANK  = 2'd2;
	localparam logic [1:0] ST_BAD_RANGE = 2'd3;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SEL,
		S_SHIFT_UP,
		S_SHIFT_DN,
		S_DONE
	} state_t;

	// Control from sequencer to scan unit
	typedef struct packed {
		logic clear;
		logic valid;
	} scan_ctl_t;

	// Scan unit results
	typedef struct packed {
		logic [CNT_W-1:0] below;
		logic [CNT_W-1:0] at_or_below;
		logic             hit;
	} scan_res_t;

endpackage

FILE: rtl/oss_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oss_scan
// Compare unit for the linear scan: counts stored keys below the search key
// and at or below the range end, and flags an exact match.
// ----------------------------------------------------------------------------
module oss_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  oss_pkg::scan_ctl_t            ctl,
	input  logic [oss_pkg::KEY_W-1:0]     data,
	input  logic [oss_pkg::KEY_W-1:0]     key_lo,
	input  logic [oss_pkg::KEY_W-1:0]     key_hi,
	output oss_pkg::scan_res_t            res
);
	import oss_pkg::*;

	logic [CNT_W-1:0] below_q;
	logic [CNT_W-1:0] le_q;
	logic             hit_q;

	// Accumulate one stored key per valid cycle (biased, unsigned compares)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			below_q <= '0;
			le_q    <= '0;
			hit_q   <= 1'b0;
		end else if (ctl.clear) begin
			below_q <= '0;
			le_q    <= '0;
			hit_q   <= 1'b0;
		end else if (ctl.valid) begin
			if (data < key_lo)
				below_q <= below_q + 1'b1;
			if (data <= key_hi)
				le_q <= le_q + 1'b1;
			if (data == key_lo)
				hit_q <= 1'b1;
		end
	end

	assign res.below       = below_q;
	assign res.at_or_below = le_q;
	assign res.hit         = hit_q;

endmodule

FILE: rtl/order_statistic_set_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_statistic_set_unit
// Bounded set of distinct signed keys kept sorted in a single-port-write,
// single-port-read store; insert, find, remove, select and range count.
// ----------------------------------------------------------------------------
// Find and range do one linear scan through the store read port; insert and
// remove follow the scan with a shift pass when the set changes; select
// reads the ranked entry directly.
// Throughput: one item at a time; the next item is taken once the result is
// handed to the output register. Reset clears the key count (set is empty);
// the key store itself is not cleared.
// ----------------------------------------------------------------------------
module order_statistic_set_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    func,
	input  logic signed [31:0]            key,
	input  logic signed [31:0]            key_end,
	input  logic [5:0]                    rank,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          found,
	output logic signed [31:0]            value,
	output logic [6:0]                    range_count,
	output logic [6:0]                    set_size,
	output logic [1:0]                    status
);
	import oss_pkg::*;

	state_t           state_q, state_d;

	logic [2:0]       func_q;
	logic [KEY_W-1:0] key_q;
	logic [KEY_W-1:0] kend_q;
	logic [5:0]       rank_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] idx_q;
	logic             chg_q;

	logic [KEY_W-1:0] mem [CAPACITY];
	logic [KEY_W-1:0] rd_data_q;
	logic             rd_vld_s1;
	logic             wr_vld_s1;
	logic [IDX_W-1:0] wr_addr_s1;

	logic             found_q;
	logic [KEY_W-1:0] value_q;
	logic [6:0]       rcount_q;
	logic [6:0]       size_q;
	logic [1:0]       status_q;
	logic             out_valid_q;

	logic             found_d;
	logic [KEY_W-1:0] value_d;
	logic [6:0]       rcount_d;
	logic [1:0]       status_d;

	scan_ctl_t        scan_ctl;
	scan_res_t        scan_res;

	logic             accept;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             shift_issue;
	logic [IDX_W-1:0] shift_waddr;
	logic             key_wr;
	logic             drained;
	logic             pass_done;
	logic             done_load;
	logic [CNT_W-1:0] idx_m1;
	logic             rank_ok;
	logic             range_bad;

	assign accept    = in_valid && in_ready;
	assign idx_m1    = idx_q - 1'b1;
	assign rank_ok   = CNT_W'(rank_q) < cnt_q;
	assign range_bad = key_q > kend_q;
	assign done_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// Scan unit
	oss_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.data   (rd_data_q),
		.key_lo (key_q),
		.key_hi (kend_q),
		.res    (scan_res)
	);

	// Sequencer outputs
	always_comb begin
		in_ready       = (state_q == S_IDLE);
		rd_en          = 1'b0;
		rd_addr        = idx_q[IDX_W-1:0];
		shift_issue    = 1'b0;
		shift_waddr    = idx_q[IDX_W-1:0];
		key_wr         = 1'b0;
		scan_ctl.clear = accept;
		scan_ctl.valid = rd_vld_s1;
		unique case (state_q)
			S_SCAN: begin
				rd_en = idx_q < cnt_q;
			end
			S_SEL: begin
				rd_en   = rank_ok;
				rd_addr = rank_q;
			end
			S_SHIFT_UP: begin
				shift_issue = idx_q > scan_res.below;
				rd_en       = shift_issue;
				rd_addr     = idx_m1[IDX_W-1:0];
				shift_waddr = idx_q[IDX_W-1:0];
				key_wr      = !shift_issue && !wr_vld_s1;
			end
			S_SHIFT_DN: begin
				shift_issue = idx_q < cnt_q;
				rd_en       = shift_issue;
				rd_addr     = idx_q[IDX_W-1:0];
				shift_waddr = idx_m1[IDX_W-1:0];
			end
			S_IDLE, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign drained   = !rd_en && !rd_vld_s1;
	assign pass_done = !shift_issue && !wr_vld_s1;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (func) inside
						OP_SELECT: state_d = S_SEL;
						OP_INSERT, OP_FIND, OP_REMOVE, OP_RANGE: state_d = S_SCAN;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_SCAN: begin
				if (drained) begin
					if (func_q == OP_INSERT && !scan_res.hit && cnt_q != CNT_W'(CAPACITY))
						state_d = S_SHIFT_UP;
					else if (func_q == OP_REMOVE && scan_res.hit)
						state_d = S_SHIFT_DN;
					else
						state_d = S_DONE;
				end
			end
			S_SEL: state_d = S_DONE;
			S_SHIFT_UP, S_SHIFT_DN: begin
				if (pass_done)
					state_d = S_DONE;
			end
			S_DONE: begin
				if (done_load)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			idx_q     <= '0;
			chg_q     <= 1'b0;
			rd_vld_s1 <= 1'b0;
			wr_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en && (state_q == S_SCAN);
			wr_vld_s1 <= shift_issue;
			if (accept) begin
				idx_q <= '0;
				chg_q <= 1'b0;
			end else begin
				case (state_q)
					S_SCAN: begin
						if (rd_en)
							idx_q <= idx_q + 1'b1;
						else if (drained && state_d == S_SHIFT_UP)
							idx_q <= cnt_q;
						else if (drained && state_d == S_SHIFT_DN)
							idx_q <= scan_res.below + 1'b1;
					end
					S_SHIFT_UP: begin
						if (shift_issue)
							idx_q <= idx_m1;
						else if (pass_done) begin
							cnt_q <= cnt_q + 1'b1;
							chg_q <= 1'b1;
						end
					end
					S_SHIFT_DN: begin
						if (shift_issue)
							idx_q <= idx_q + 1'b1;
						else if (pass_done) begin
							cnt_q <= cnt_q - 1'b1;
							chg_q <= 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Request payload
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			key_q  <= key ^ SIGN_FLIP;
			kend_q <= key_end ^ SIGN_FLIP;
			rank_q <= rank;
		end
		if (shift_issue)
			wr_addr_s1 <= shift_waddr;
	end

	// Key store: one read, one write per cycle
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= mem[rd_addr];
		if (wr_vld_s1)
			mem[wr_addr_s1] <= rd_data_q;
		else if (key_wr)
			mem[scan_res.below[IDX_W-1:0]] <= key_q;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result fields for the finished request
	always_comb begin
		found_d  = 1'b0;
		value_d  = '0;
		rcount_d = '0;
		status_d = ST_OK;
		case (func_q)
			OP_INSERT: begin
				found_d = chg_q;
				if (!scan_res.hit && !chg_q)
					status_d = ST_FULL;
			end
			OP_FIND:   found_d = scan_res.hit;
			OP_REMOVE: found_d = chg_q;
			OP_SELECT: begin
				if (rank_ok)
					value_d = rd_data_q ^ SIGN_FLIP;
				else
					status_d = ST_BAD_RANK;
			end
			OP_RANGE: begin
				if (range_bad)
					status_d = ST_BAD_RANGE;
				else
					rcount_d = 7'(scan_res.at_or_below - scan_res.below);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (done_load) begin
			found_q  <= found_d;
			value_q  <= value_d;
			rcount_q <= rcount_d;
			status_q <= status_d;
			size_q   <= 7'(cnt_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign value       = value_q;
	assign range_count = rcount_q;
	assign set_size    = size_q;
	assign status      = status_q;

endmodule

FILE: tb/oss_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oss_result_checker
// Watches both channels of the order statistic set unit. It keeps its own
// sorted copy of the key set, computes the reply for every request transfer
// and compares each result transfer field by field with the oldest reply
// still awaited.
// ----------------------------------------------------------------------------
module oss_result_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [2:0]         func,
	input  logic signed [31:0] key,
	input  logic signed [31:0] key_end,
	input  logic [5:0]         rank,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               found,
	input  logic signed [31:0] value,
	input  logic [6:0]         range_count,
	input  logic [6:0]         set_size,
	input  logic [1:0]         status,
	output int                 mismatches,
	output int                 awaited
);
	import oss_pkg::*;

	typedef struct packed {
		logic               found;
		logic signed [31:0] value;
		logic [6:0]         range_count;
		logic [6:0]         set_size;
		logic [1:0]         status;
	} set_reply_t;

	// Predicted contents: held_keys[0 .. held_count-1], ascending signed order
	logic signed [KEY_W-1:0] held_keys [CAPACITY];
	int                      held_count;
	set_reply_t              awaited_replies [$];
	set_reply_t              oldest;

	// Apply one request to the predicted set and return the reply it earns
	function automatic set_reply_t apply_request(logic [2:0] op, logic signed [31:0] k,
			logic signed [31:0] k_end, logic [5:0] r);
		set_reply_t rep;
		int         pos;
		int         i;
		bit         present;
		rep = '0;
		pos = 0;
		while (pos < held_count && held_keys[pos] < k)
			pos++;
		present = (pos < held_count) && (held_keys[pos] == k);
		case (op)
			OP_INSERT: begin
				// duplicates leave the set alone, even when it is full
				if (!present) begin
					if (held_count >= CAPACITY) begin
						rep.status = ST_FULL;
					end else begin
						for (i = held_count; i > pos; i--)
							held_keys[i] = held_keys[i-1];
						held_keys[pos] = k;
						held_count++;
						rep.found = 1'b1;
					end
				end
			end
			OP_FIND: begin
				rep.found = present;
			end
			OP_REMOVE: begin
				if (present) begin
					for (i = pos; i < held_count - 1; i++)
						held_keys[i] = held_keys[i+1];
					held_count--;
					rep.found = 1'b1;
				end
			end
			OP_SELECT: begin
				if (r < held_count)
					rep.value = held_keys[r];
				else
					rep.status = ST_BAD_RANK;
			end
			OP_RANGE: begin
				if (k > k_end) begin
					rep.status = ST_BAD_RANGE;
				end else begin
					for (i = 0; i < held_count; i++)
						if (held_keys[i] >= k && held_keys[i] <= k_end)
							rep.range_count++;
				end
			end
			default: begin
				// spare codes: no change, only the size is reported
			end
		endcase
		rep.set_size = 7'(held_count);
		return rep;
	endfunction

	task automatic compare_field(string name, logic signed [32:0] want, logic signed [32:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Result transfer is checked before the request transfer of the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count = 0;
			awaited_replies.delete();
			awaited = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_replies.size() == 0) begin
					$display("%0t ns: result transfer with no request awaiting it", $time);
					mismatches++;
				end else begin
					oldest = awaited_replies.pop_front();
					compare_field("found", oldest.found, found);
					compare_field("value", oldest.value, value);
					compare_field("range_count", oldest.range_count, range_count);
					compare_field("set_size", oldest.set_size, set_size);
					compare_field("status", oldest.status, status);
				end
			end
			if (in_valid && in_ready)
				awaited_replies.push_back(apply_request(func, key, key_end, rank));
			awaited = awaited_replies.size();
		end
	end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the order statistic set unit with a directed opening (extremes,
// every operation, duplicates, misses, bad rank, reversed range, spare codes)
// and then random phases that fill, drain, mix and scramble the set, with
// random gaps on both channels and a couple of long output stalls. The
// checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;
	import oss_pkg::*;

	localparam int ITEMS      = 1450;
	localparam int CYCLE_CAP  = 1_000_000;
	localparam int POOL_DEPTH = 96;
	localparam int MAX_GAP    = 18;
	localparam int LONG_HOLD  = 400;
	localparam int TAIL       = 200;

	// spare operation codes, decoded as no-ops
	localparam logic [2:0] OP_NOP_A = 3'd5;
	localparam logic [2:0] OP_NOP_B = 3'd6;
	localparam logic [2:0] OP_NOP_C = 3'd7;

	typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_NOISE} phase_kind_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [2:0]         func;
	logic signed [31:0] key;
	logic signed [31:0] key_end;
	logic [5:0]         rank;
	logic               out_valid;
	logic               out_ready;
	logic               found;
	logic signed [31:0] value;
	logic [6:0]         range_count;
	logic [6:0]         set_size;
	logic [1:0]         status;

	int                 mismatches;
	int                 awaited;
	int                 cycles;
	int                 sent;
	bit                 steady_in;
	logic signed [31:0] key_pool [POOL_DEPTH];

	order_statistic_set_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.key         (key),
		.key_end     (key_end),
		.rank        (rank),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.value       (value),
		.range_count (range_count),
		.set_size    (set_size),
		.status      (status)
	);

	oss_result_checker result_watch (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.key         (key),
		.key_end     (key_end),
		.rank        (rank),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.value       (value),
		.range_count (range_count),
		.set_size    (set_size),
		.status      (status),
		.mismatches  (mismatches),
		.awaited     (awaited)
	);

	// Clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Watchdog
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_CAP) begin
			$display("status: fail");
			$finish;
		end
	end

	// Offer one request; called and returning at a falling edge
	task automatic offer_request(logic [2:0] op, logic signed [31:0] k,
			logic signed [31:0] k_end, logic [5:0] r);
		int gap;
		gap = steady_in ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		func     <= op;
		key      <= k;
		key_end  <= k_end;
		rank     <= r;
		do @(posedge clk); while (!in_ready);
		sent++;
		@(negedge clk);
	endtask

	// Pause the sender until every awaited result has come back
	task automatic settle_set();
		in_valid <= 1'b0;
		wait (awaited == 0);
		@(negedge clk);
	endtask

	// Keys mostly from a shared pool so that hits and duplicates are common
	function automatic logic signed [31:0] pick_key(bit wide);
		int roll;
		roll = $urandom_range(0, 99);
		if (wide || roll < 15)
			return $urandom;
		else if (roll < 25)
			return 32'($urandom_range(0, 8) - 4);
		else
			return key_pool[$urandom_range(0, POOL_DEPTH - 1)];
	endfunction

	function automatic logic [2:0] pick_op(phase_kind_t kind);
		int roll;
		roll = $urandom_range(0, 99);
		case (kind)
			PH_FILL:
				return roll < 80 ? OP_INSERT : roll < 87 ? OP_FIND :
					roll < 92 ? OP_SELECT : roll < 96 ? OP_RANGE : OP_REMOVE;
			PH_DRAIN:
				return roll < 60 ? OP_REMOVE : roll < 75 ? OP_FIND :
					roll < 85 ? OP_SELECT : roll < 95 ? OP_RANGE : OP_INSERT;
			PH_MIXED:
				return 3'($urandom_range(OP_INSERT, OP_RANGE));
			default:
				return 3'($urandom_range(OP_INSERT, OP_NOP_C));
		endcase
	endfunction

	// Result side: random stalls, stretches of none, two long hold-offs
	initial begin : result_side
		int stall;
		int taken;
		bit steady_out;
		out_ready  = 1'b0;
		taken      = 0;
		steady_out = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (taken == 150 || taken == 800)
				stall = LONG_HOLD;
			else
				stall = steady_out ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
			if (taken % 60 == 0)
				steady_out = ($urandom_range(0, 2) == 0);
			@(negedge clk);
		end
	end

	// Stimulus and verdict
	initial begin : request_side
		phase_kind_t        kind;
		int                 phase_len;
		int                 phase_no;
		int                 roll;
		int                 i;
		logic [2:0]         op;
		logic signed [31:0] k;
		logic signed [31:0] k_end;
		logic [5:0]         r;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		func      = OP_INSERT;
		key       = '0;
		key_end   = '0;
		rank      = '0;
		sent      = 0;
		steady_in = 1'b0;
		for (i = 0; i < POOL_DEPTH; i++)
			key_pool[i] = $urandom;
		key_pool[0] = 32'sh8000_0000;
		key_pool[1] = 32'sh7fff_ffff;
		key_pool[2] = 32'sh0000_0000;
		key_pool[3] = -32'sd1;
		key_pool[4] = 32'sh8000_0001;
		key_pool[5] = 32'sh7fff_fffe;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed opening on an empty set, then a small populated one
		offer_request(OP_FIND,   32'sd0, 32'sd0, 6'd0);
		offer_request(OP_SELECT, 32'sd0, 32'sd0, 6'd0);
		offer_request(OP_RANGE,  32'sh8000_0000, 32'sh7fff_ffff, 6'd0);
		offer_request(OP_INSERT, 32'sh8000_0000, 32'sd0, 6'd0);
		offer_request(OP_INSERT, 32'sh7fff_ffff, 32'sd0, 6'd0);
		offer_request(OP_INSERT, 32'sd0, 32'sd0, 6'd0);
		offer_request(OP_INSERT, -32'sd1, 32'sd0, 6'd0);
		offer_request(OP_INSERT, 32'sh7fff_ffff, 32'sd0, 6'd0);
		offer_request(OP_FIND,   32'sh8000_0000, 32'sd0, 6'd0);
		offer_request(OP_FIND,   32'sd1, 32'sd0, 6'd0);
		offer_request(OP_SELECT, 32'sd0, 32'sd0, 6'd0);
		offer_request(OP_SELECT, 32'sd0, 32'sd0, 6'd3);
		offer_request(OP_SELECT, 32'sd0, 32'sd0, 6'd63);
		offer_request(OP_RANGE,  32'sh8000_0000, 32'sh7fff_ffff, 6'd0);
		offer_request(OP_RANGE,  32'sd0, 32'sd0, 6'd0);
		offer_request(OP_RANGE,  32'sd5, -32'sd5, 6'd0);
		offer_request(OP_RANGE,  32'sh7fff_ffff, 32'sh8000_0000, 6'd0);
		offer_request(OP_RANGE,  -32'sd1, -32'sd1, 6'd0);
		offer_request(OP_REMOVE, 32'sd0, 32'sd0, 6'd0);
		offer_request(OP_REMOVE, 32'sd0, 32'sd0, 6'd0);
		offer_request(OP_NOP_A,  32'sh7fff_ffff, -32'sd1, 6'd63);
		offer_request(OP_NOP_B,  -32'sd1, 32'sh8000_0000, 6'd21);
		offer_request(OP_NOP_C,  32'sh8000_0000, 32'sh7fff_ffff, 6'd42);
		offer_request(OP_REMOVE, 32'sh8000_0000, 32'sd0, 6'd0);
		offer_request(OP_REMOVE, 32'sh7fff_ffff, 32'sd0, 6'd0);
		settle_set();

		// Random phases of fill, drain, mixed and noise requests
		phase_no = 0;
		while (sent < ITEMS) begin
			roll = $urandom_range(0, 99);
			if (phase_no == 0 || roll < 35)
				kind = PH_FILL;
			else if (roll < 55)
				kind = PH_DRAIN;
			else if (roll < 85)
				kind = PH_MIXED;
			else
				kind = PH_NOISE;
			phase_len = $urandom_range(60, 140);
			steady_in = ($urandom_range(0, 3) == 0);
			for (i = 0; i < phase_len && sent < ITEMS; i++) begin
				op    = pick_op(kind);
				k     = pick_key(kind == PH_NOISE);
				k_end = ($urandom_range(0, 9) < 3) ? k : pick_key(kind == PH_NOISE);
				r     = $urandom_range(0, 1) ? 6'($urandom_range(0, 63))
					: 6'($urandom_range(0, 15));
				offer_request(op, k, k_end, r);
			end
			settle_set();
			phase_no++;
		end

		repeat (TAIL) @(posedge clk);
		if (mismatches == 0 && awaited == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: files.f
rtl/oss_pkg.sv
rtl/oss_scan.sv
rtl/order_statistic_set_unit.sv
tb/oss_result_checker.sv
tb/tb_top.sv
